// File: src/fupa_pkg.sv
// Shared types and constants for the fixed unit pool allocator.
package fupa_pkg;

	localparam int POOL_UNITS_DEF = 256;

	localparam int UNITS_W = 9;
	localparam int BYTES_W = 16;
	localparam int INDEX_W = 8;
	localparam int STATUS_W = 3;

	localparam logic [UNITS_W-1:0] UNITS_RST = 9'd256;
	localparam logic [BYTES_W-1:0] BYTES_RST = 16'd64;

	localparam logic CFG_UNITS_IN_USE = 1'b0;
	localparam logic CFG_UNIT_BYTES = 1'b1;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK = 3'd0,
		STAT_SIZE = 3'd1,
		STAT_EMPTY = 3'd2,
		STAT_NOT_USED = 3'd3,
		STAT_BAD_INDEX = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic sweep_clr;
		logic sweep_step;
		logic rebuild;
		logic load_req;
		logic execute;
	} ctl_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} dp_stat_t;

endpackage

// File: src/fupa_ctrl.sv
// Controller state machine: link memory sweep, request accept and execute.
module fupa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cfg_wr_en,
	input  fupa_pkg::dp_stat_t stat,
	output fupa_pkg::ctl_cmd_t cmd,
	output logic               busy
);

	fupa_pkg::ctl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fupa_pkg::S_SWEEP;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fupa_pkg::S_SWEEP: begin
				if (!cfg_wr_en && stat.sweep_last) begin
					state_nxt = fupa_pkg::S_IDLE;
				end
			end
			fupa_pkg::S_IDLE: begin
				if (start) begin
					state_nxt = fupa_pkg::S_EXEC;
				end else if (cfg_wr_en) begin
					state_nxt = fupa_pkg::S_SWEEP;
				end
			end
			fupa_pkg::S_EXEC: begin
				state_nxt = cfg_wr_en ? fupa_pkg::S_SWEEP : fupa_pkg::S_IDLE;
			end
			default: state_nxt = fupa_pkg::S_SWEEP;
		endcase
	end

	always_comb begin
		cmd.sweep_clr = cfg_wr_en;
		cmd.sweep_step = (state_q == fupa_pkg::S_SWEEP);
		cmd.rebuild = (state_q == fupa_pkg::S_SWEEP) && stat.sweep_last && !cfg_wr_en;
		cmd.load_req = (state_q == fupa_pkg::S_IDLE) && start;
		cmd.execute = (state_q == fupa_pkg::S_EXEC);
		busy = (state_q != fupa_pkg::S_IDLE);
	end

endmodule

// File: src/fupa_dpath.sv
// Datapath: config registers, link memory, free list head and result registers.
module fupa_dpath #(
	parameter int POOL_UNITS = fupa_pkg::POOL_UNITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fupa_pkg::ctl_cmd_t             cmd,
	output fupa_pkg::dp_stat_t             stat,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_index,
	input  logic [fupa_pkg::BYTES_W-1:0]   cfg_data,
	input  logic                           req_type,
	input  logic [fupa_pkg::BYTES_W-1:0]   req_size,
	input  logic                           use_pool,
	input  logic [fupa_pkg::INDEX_W-1:0]   unit_index,
	output logic                           done,
	output logic [fupa_pkg::STATUS_W-1:0]  status,
	output logic [fupa_pkg::INDEX_W-1:0]   granted_unit
);

	localparam int IW = $clog2(POOL_UNITS);
	localparam int LW = $clog2(POOL_UNITS + 1);
	localparam int CW = (LW > fupa_pkg::UNITS_W) ? LW : fupa_pkg::UNITS_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(POOL_UNITS - 1);
	localparam logic [CW-1:0] POOL_C = CW'(POOL_UNITS);

	logic [fupa_pkg::UNITS_W-1:0] units_q;
	logic [fupa_pkg::BYTES_W-1:0] bytes_q;

	logic [LW-1:0] link_mem [POOL_UNITS];
	logic [LW-1:0] link_s1;
	logic [IW-1:0] sweep_cnt_q;

	logic [IW-1:0] head_q;
	logic          head_valid_q;

	logic                         req_type_q;
	logic [fupa_pkg::BYTES_W-1:0] req_size_q;
	logic                         use_pool_q;
	logic [fupa_pkg::INDEX_W-1:0] unit_idx_q;

	logic                          done_q;
	logic [fupa_pkg::STATUS_W-1:0] status_q;
	logic [fupa_pkg::INDEX_W-1:0]  granted_q;

	logic [CW+fupa_pkg::UNITS_W-1:0] units_x;
	logic [CW-1:0]                   units_ext, count, count_m1, idx_ext;
	logic [IW+fupa_pkg::INDEX_W-1:0] idx_x, grant_x;
	logic [LW+IW-1:0]                head_x, sweep_x;
	logic [LW-1:0]                   head_p1, push_link, sweep_val, link_m1;
	logic [IW-1:0]                   idx_iw, nxt_head;
	logic                            nxt_valid, wr_free;
	fupa_pkg::status_t               res_status;
	logic [fupa_pkg::INDEX_W-1:0]    res_grant;

	assign units_x = {{CW{1'b0}}, units_q};
	assign units_ext = units_x[CW-1:0];
	assign count = (units_ext > POOL_C) ? POOL_C : units_ext;
	assign count_m1 = count - CW'(1);
	assign idx_ext = {{(CW-fupa_pkg::INDEX_W){1'b0}}, unit_idx_q};
	assign idx_x = {{IW{1'b0}}, unit_idx_q};
	assign idx_iw = idx_x[IW-1:0];
	assign grant_x = {{fupa_pkg::INDEX_W{1'b0}}, head_q};
	assign head_x = {{LW{1'b0}}, head_q};
	assign head_p1 = head_x[LW-1:0] + LW'(1);
	assign push_link = head_valid_q ? head_p1 : '0;
	assign sweep_x = {{LW{1'b0}}, sweep_cnt_q};
	assign sweep_val = sweep_x[LW-1:0];
	assign link_m1 = link_s1 - LW'(1);

	assign stat.sweep_last = (sweep_cnt_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q <= fupa_pkg::UNITS_RST;
			bytes_q <= fupa_pkg::BYTES_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fupa_pkg::CFG_UNITS_IN_USE: units_q <= cfg_data[fupa_pkg::UNITS_W-1:0];
				fupa_pkg::CFG_UNIT_BYTES:   bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
		end else if (cmd.sweep_clr) begin
			sweep_cnt_q <= '0;
		end else if (cmd.sweep_step) begin
			sweep_cnt_q <= sweep_cnt_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_step) begin
			link_mem[sweep_cnt_q] <= sweep_val;
		end else if (wr_free) begin
			link_mem[idx_iw] <= push_link;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			link_s1 <= link_mem[head_q];
			req_type_q <= req_type;
			req_size_q <= req_size;
			use_pool_q <= use_pool;
			unit_idx_q <= unit_index;
		end
	end

	always_comb begin
		nxt_head = head_q;
		nxt_valid = head_valid_q;
		res_status = fupa_pkg::STAT_OK;
		res_grant = '0;
		wr_free = 1'b0;
		if (req_type_q == fupa_pkg::REQ_ALLOC) begin
			if (req_size_q > bytes_q) begin
				res_status = fupa_pkg::STAT_SIZE;
			end else if (!use_pool_q) begin
				res_status = fupa_pkg::STAT_NOT_USED;
			end else if (!head_valid_q) begin
				res_status = fupa_pkg::STAT_EMPTY;
			end else begin
				res_grant = grant_x[fupa_pkg::INDEX_W-1:0];
				if (link_s1 == '0) begin
					nxt_valid = 1'b0;
					nxt_head = '0;
				end else begin
					nxt_head = link_m1[IW-1:0];
				end
			end
		end else begin
			if (idx_ext >= count) begin
				res_status = fupa_pkg::STAT_BAD_INDEX;
			end else begin
				wr_free = cmd.execute;
				nxt_head = idx_iw;
				nxt_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			head_valid_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.execute;
			if (cmd.rebuild) begin
				head_q <= count_m1[IW-1:0];
				head_valid_q <= (count != '0);
			end else if (cmd.execute) begin
				head_q <= nxt_head;
				head_valid_q <= nxt_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= res_status;
			granted_q <= res_grant;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign granted_unit = granted_q;

endmodule

// File: src/fixed_unit_pool_allocator_core.sv
// Fixed unit pool allocator: top level joining controller and datapath.
// Timing: a request transferred while idle is registered with the head unit's link, executed in
// S_EXEC, and its result is registered with done high. busy is high while a request executes, so
// a new request is taken only after the last one is through, as the head unit's link is read first.
// Reset and every config write run a link memory sweep with busy high.
// The receiver cannot stall; done is a single-cycle strobe.
module fixed_unit_pool_allocator_core #(
	parameter int POOL_UNITS = fupa_pkg::POOL_UNITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_index,
	input  logic [fupa_pkg::BYTES_W-1:0]   cfg_data,
	input  logic                           req_type,
	input  logic [fupa_pkg::BYTES_W-1:0]   req_size,
	input  logic                           use_pool,
	input  logic [fupa_pkg::INDEX_W-1:0]   unit_index,
	output logic                           done,
	output logic [fupa_pkg::STATUS_W-1:0]  status,
	output logic [fupa_pkg::INDEX_W-1:0]   granted_unit
);

	fupa_pkg::ctl_cmd_t cmd;
	fupa_pkg::dp_stat_t stat;

	fupa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_wr_en (cfg_wr_en),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	fupa_dpath #(
		.POOL_UNITS (POOL_UNITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.req_size     (req_size),
		.use_pool     (use_pool),
		.unit_index   (unit_index),
		.done         (done),
		.status       (status),
		.granted_unit (granted_unit)
	);

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("transfer without result two cycles later");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after transfer");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

	a_fail_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != fupa_pkg::STAT_OK)) |-> (granted_unit == '0))
		else $error("failed request returned a unit");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the pool allocator: directed and random requests vs. a predictor.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNITS_MAX = fupa_pkg::POOL_UNITS_DEF;
	localparam int STALL_LIMIT = 5000;

	typedef enum {
		K_REQ,
		K_CFG,
		K_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t kind;
		logic req_type;
		logic [fupa_pkg::BYTES_W-1:0] req_size;
		logic use_pool;
		logic [fupa_pkg::INDEX_W-1:0] unit_index;
		logic cfg_index;
		logic [fupa_pkg::BYTES_W-1:0] cfg_data;
		int idle_pct;
	} step_t;

	typedef struct packed {
		fupa_pkg::status_t status;
		logic [fupa_pkg::INDEX_W-1:0] unit;
	} reply_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = fupa_pkg::CFG_UNITS_IN_USE;
	logic [fupa_pkg::BYTES_W-1:0] cfg_data = '0;
	logic req_type = fupa_pkg::REQ_ALLOC;
	logic [fupa_pkg::BYTES_W-1:0] req_size = '0;
	logic use_pool = 1'b0;
	logic [fupa_pkg::INDEX_W-1:0] unit_index = '0;
	logic done;
	logic [fupa_pkg::STATUS_W-1:0] status;
	logic [fupa_pkg::INDEX_W-1:0] granted_unit;

	fixed_unit_pool_allocator_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_type(req_type),
		.req_size(req_size),
		.use_pool(use_pool),
		.unit_index(unit_index),
		.done(done),
		.status(status),
		.granted_unit(granted_unit)
	);

	// predictor state
	logic [fupa_pkg::UNITS_W-1:0] link_mem [UNITS_MAX];
	logic [fupa_pkg::UNITS_W-1:0] head;
	bit head_ok;
	logic [fupa_pkg::UNITS_W-1:0] units_reg;
	logic [fupa_pkg::BYTES_W-1:0] bytes_reg;

	step_t pend[$];
	reply_t replies_due[$];
	int fails = 0;
	int stall_cnt = 0;
	bit sweep_wait = 1'b0;
	int plan_units;
	int plan_bytes;

	function automatic int pool_size();
		return (units_reg > UNITS_MAX) ? UNITS_MAX : int'(units_reg);
	endfunction

	function automatic void pool_rebuild();
		for (int i = 0; i < UNITS_MAX; i++)
			link_mem[i] = fupa_pkg::UNITS_W'(i);
		head_ok = (pool_size() != 0);
		head = head_ok ? fupa_pkg::UNITS_W'(pool_size() - 1) : '0;
	endfunction

	function automatic void pool_write_reg(logic idx, logic [fupa_pkg::BYTES_W-1:0] data);
		if (idx == fupa_pkg::CFG_UNITS_IN_USE)
			units_reg = data[fupa_pkg::UNITS_W-1:0];
		else
			bytes_reg = data;
		pool_rebuild();
	endfunction

	function automatic reply_t pool_serve(logic rtype, logic [fupa_pkg::BYTES_W-1:0] size,
			logic use_it, logic [fupa_pkg::INDEX_W-1:0] idx);
		reply_t r;
		logic [fupa_pkg::UNITS_W-1:0] link;
		r.status = fupa_pkg::STAT_OK;
		r.unit = '0;
		if (rtype == fupa_pkg::REQ_ALLOC) begin
			if (size > bytes_reg) begin
				r.status = fupa_pkg::STAT_SIZE;
			end else if (!use_it) begin
				r.status = fupa_pkg::STAT_NOT_USED;
			end else if (!head_ok) begin
				r.status = fupa_pkg::STAT_EMPTY;
			end else begin
				link = link_mem[head[fupa_pkg::INDEX_W-1:0]];
				r.unit = head[fupa_pkg::INDEX_W-1:0];
				if (link == 0) begin
					head_ok = 1'b0;
					head = '0;
				end else begin
					head = link - 1'b1;
				end
			end
		end else if (int'(idx) >= pool_size()) begin
			r.status = fupa_pkg::STAT_BAD_INDEX;
		end else begin
			link_mem[idx] = head_ok ? head + 1'b1 : '0;
			head = {1'b0, idx};
			head_ok = 1'b1;
		end
		return r;
	endfunction

	task automatic add_req(logic rtype, logic [fupa_pkg::BYTES_W-1:0] size, logic use_it,
			logic [fupa_pkg::INDEX_W-1:0] idx, int pct);
		step_t s;
		s.kind = K_REQ;
		s.req_type = rtype;
		s.req_size = size;
		s.use_pool = use_it;
		s.unit_index = idx;
		s.cfg_index = fupa_pkg::CFG_UNITS_IN_USE;
		s.cfg_data = '0;
		s.idle_pct = pct;
		pend.push_back(s);
	endtask

	task automatic add_cfg(logic idx, logic [fupa_pkg::BYTES_W-1:0] data);
		step_t s;
		s.kind = K_CFG;
		s.req_type = fupa_pkg::REQ_ALLOC;
		s.req_size = '0;
		s.use_pool = 1'b0;
		s.unit_index = '0;
		s.cfg_index = idx;
		s.cfg_data = data;
		s.idle_pct = 0;
		pend.push_back(s);
		if (idx == fupa_pkg::CFG_UNITS_IN_USE)
			plan_units = (data[fupa_pkg::UNITS_W-1:0] > UNITS_MAX) ? UNITS_MAX :
				int'(data[fupa_pkg::UNITS_W-1:0]);
		else
			plan_bytes = int'(data);
	endtask

	task automatic add_drain();
		step_t s;
		s.kind = K_DRAIN;
		s.req_type = fupa_pkg::REQ_ALLOC;
		s.req_size = '0;
		s.use_pool = 1'b0;
		s.unit_index = '0;
		s.cfg_index = fupa_pkg::CFG_UNITS_IN_USE;
		s.cfg_data = '0;
		s.idle_pct = 0;
		pend.push_back(s);
	endtask

	task automatic add_random(int n, int pct, bit with_drain);
		logic rtype;
		logic [fupa_pkg::BYTES_W-1:0] size;
		logic [fupa_pkg::INDEX_W-1:0] idx;
		int r;
		for (int k = 0; k < n; k++) begin
			if (with_drain && k == n / 2)
				add_drain();
			rtype = ($urandom_range(99) < 55) ? fupa_pkg::REQ_ALLOC : fupa_pkg::REQ_FREE;
			r = $urandom_range(99);
			if (r < 80)
				size = fupa_pkg::BYTES_W'($urandom_range(plan_bytes));
			else if (r < 90 || plan_bytes == 65535)
				size = fupa_pkg::BYTES_W'($urandom);
			else
				size = fupa_pkg::BYTES_W'(plan_bytes + 1);
			if (plan_units > 0 && $urandom_range(99) < 85)
				idx = fupa_pkg::INDEX_W'($urandom_range(plan_units - 1));
			else
				idx = fupa_pkg::INDEX_W'($urandom);
			add_req(rtype, size, $urandom_range(99) < 90, idx, pct);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// driver: one decision per edge, each input assigned at most once
	always @(posedge clk) begin : drive_p
		step_t nxt;
		if (arst_n) begin
			if (start && !busy)
				replies_due.push_back(pool_serve(req_type, req_size, use_pool, unit_index));
			if (sweep_wait && busy)
				sweep_wait = 1'b0;
			if (!(start && busy)) begin
				if (cfg_wr_en) begin
					pool_write_reg(cfg_index, cfg_data);
					cfg_wr_en <= 1'b0;
					sweep_wait = 1'b1;
					start <= 1'b0;
				end else if (pend.size() == 0 || sweep_wait) begin
					start <= 1'b0;
				end else begin
					nxt = pend[0];
					case (nxt.kind)
						K_REQ: begin
							if ($urandom_range(99) < nxt.idle_pct) begin
								start <= 1'b0;
							end else begin
								void'(pend.pop_front());
								req_type <= nxt.req_type;
								req_size <= nxt.req_size;
								use_pool <= nxt.use_pool;
								unit_index <= nxt.unit_index;
								start <= 1'b1;
							end
						end
						K_CFG: begin
							start <= 1'b0;
							if (replies_due.size() == 0 && !busy) begin
								void'(pend.pop_front());
								cfg_index <= nxt.cfg_index;
								cfg_data <= nxt.cfg_data;
								cfg_wr_en <= 1'b1;
							end
						end
						default: begin
							start <= 1'b0;
							if (replies_due.size() == 0)
								void'(pend.pop_front());
						end
					endcase
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : check_p
		reply_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("result with no transfer pending: status %0d unit %0d",
					status, granted_unit);
				fails++;
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fails++;
				end
				if (granted_unit !== want.unit) begin
					$error("granted_unit: expected %0d, got %0d", want.unit, granted_unit);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_wr_en)
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int phase_pct [3];
		int unit_set [9];
		int byte_set [9];
		phase_pct = '{21, 63, 0};
		unit_set = '{256, 3, 1, 60, 511, 16, 2, 200, 256};
		byte_set = '{64, 65535, 0, 1000, 7, 65535, 64, 300, 40000};
		units_reg = fupa_pkg::UNITS_RST;
		bytes_reg = fupa_pkg::BYTES_RST;
		pool_rebuild();
		plan_units = UNITS_MAX;
		plan_bytes = fupa_pkg::BYTES_RST;

		// directed: checks order, double free, small pool, empty pool, saturation, size extremes
		add_req(fupa_pkg::REQ_ALLOC, 16'd0, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd64, 1'b1, 8'hFF, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd65, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'hFFFF, 1'b0, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd10, 1'b0, 8'd0, 0);
		add_req(fupa_pkg::REQ_FREE, 16'hFFFF, 1'b0, 8'd255, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd64, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_FREE, 16'd0, 1'b1, 8'd254, 0);
		add_req(fupa_pkg::REQ_FREE, 16'd0, 1'b1, 8'd254, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd1, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd1, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd1, 1'b1, 8'd0, 0);
		add_cfg(fupa_pkg::CFG_UNITS_IN_USE, 16'd3);
		add_req(fupa_pkg::REQ_FREE, 16'd0, 1'b1, 8'd3, 0);
		add_req(fupa_pkg::REQ_FREE, 16'd0, 1'b1, 8'd255, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd0, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd0, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd0, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd0, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd0, 1'b0, 8'd0, 0);
		add_req(fupa_pkg::REQ_FREE, 16'd0, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd0, 1'b1, 8'd0, 0);
		add_cfg(fupa_pkg::CFG_UNITS_IN_USE, 16'd0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd0, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_FREE, 16'd0, 1'b1, 8'd0, 0);
		add_cfg(fupa_pkg::CFG_UNITS_IN_USE, 16'h01FF);
		add_cfg(fupa_pkg::CFG_UNIT_BYTES, 16'd0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd0, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_ALLOC, 16'd1, 1'b1, 8'd0, 0);
		add_req(fupa_pkg::REQ_FREE, 16'd0, 1'b1, 8'd255, 0);
		add_cfg(fupa_pkg::CFG_UNIT_BYTES, 16'hFFFF);
		add_req(fupa_pkg::REQ_ALLOC, 16'hFFFF, 1'b1, 8'd0, 0);

		for (int p = 0; p < 3; p++) begin
			for (int s = 0; s < 3; s++) begin
				add_cfg(fupa_pkg::CFG_UNITS_IN_USE,
					fupa_pkg::BYTES_W'(unit_set[p*3+s]) |
					(fupa_pkg::BYTES_W'($urandom) & 16'hFE00));
				add_cfg(fupa_pkg::CFG_UNIT_BYTES, fupa_pkg::BYTES_W'(byte_set[p*3+s]));
				add_random(100, phase_pct[p], s == 0);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pend.size() != 0 || start || cfg_wr_en || replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
